// File: hdl/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and constants for the telegram decoder with re-check.
// ----------------------------------------------------------------------------
package tdr_pkg;

   localparam int TELEGRAM_BYTES = 12;
   localparam int SYMBOL_COUNT   = 40;
   localparam int ID_WIDTH       = 30;
   localparam int STATUS_WIDTH   = 10;
   localparam int POLY_WIDTH     = 40;
   localparam int POS_WIDTH      = 4;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 48;

   localparam logic [ID_WIDTH-1:0] ID_LIMIT_RESET = {ID_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      REG_CODING_POLY = 2'd0,
      REG_PREAMBLE_1  = 2'd1,
      REG_PREAMBLE_2  = 2'd2,
      REG_ID_LIMIT    = 2'd3
   } reg_index_type;

   typedef logic [TELEGRAM_BYTES-1:0][7:0] telegram_type;

   typedef struct packed {
      logic [POLY_WIDTH-1:0] coding_polynomial;
      logic [7:0]            preamble_first;
      logic [7:0]            preamble_second;
      logic [ID_WIDTH-1:0]   display_id_limit;
   } csr_type;

   typedef struct packed {
      logic                    telegram_ok;
      logic                    id_in_range;
      logic                    code_match;
      logic                    preamble_match;
      logic [STATUS_WIDTH-1:0] status_bits;
      logic [ID_WIDTH-1:0]     identifier;
   } result_type;

endpackage

// File: hdl/tdr_csr.sv
// ----------------------------------------------------------------------------
// tdr_csr
// Configuration register file behind the register bus port.
// ----------------------------------------------------------------------------
module tdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tdr_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [tdr_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [tdr_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output tdr_pkg::csr_type                    regs
);

   tdr_pkg::csr_type       regs_ff;
   tdr_pkg::csr_type       regs_in;
   tdr_pkg::reg_index_type reg_sel;
   logic                   wr_en;

   // registers sit on 8-byte boundaries
   assign reg_sel = tdr_pkg::reg_index_type'(paddr[4:3]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (reg_sel)
            tdr_pkg::REG_CODING_POLY:
               regs_in.coding_polynomial = pwdata[tdr_pkg::POLY_WIDTH-1:0];
            tdr_pkg::REG_PREAMBLE_1:  regs_in.preamble_first  = pwdata[7:0];
            tdr_pkg::REG_PREAMBLE_2:  regs_in.preamble_second = pwdata[7:0];
            tdr_pkg::REG_ID_LIMIT:
               regs_in.display_id_limit = pwdata[tdr_pkg::ID_WIDTH-1:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         tdr_pkg::REG_CODING_POLY:
            prdata = {{(tdr_pkg::CSR_DATA_WIDTH-tdr_pkg::POLY_WIDTH){1'b0}},
                      regs_ff.coding_polynomial};
         tdr_pkg::REG_PREAMBLE_1:
            prdata = {{(tdr_pkg::CSR_DATA_WIDTH-8){1'b0}}, regs_ff.preamble_first};
         tdr_pkg::REG_PREAMBLE_2:
            prdata = {{(tdr_pkg::CSR_DATA_WIDTH-8){1'b0}}, regs_ff.preamble_second};
         tdr_pkg::REG_ID_LIMIT:
            prdata = {{(tdr_pkg::CSR_DATA_WIDTH-tdr_pkg::ID_WIDTH){1'b0}},
                      regs_ff.display_id_limit};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.coding_polynomial <= '0;
         regs_ff.preamble_first    <= '0;
         regs_ff.preamble_second   <= '0;
         regs_ff.display_id_limit  <= tdr_pkg::ID_LIMIT_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// File: hdl/tdr_collect.sv
// ----------------------------------------------------------------------------
// tdr_collect
// Frames incoming bytes into a 12-byte telegram buffer and flags completion.
// ----------------------------------------------------------------------------
module tdr_collect (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            byte_data,
   input  logic                  start_flag,
   input  logic                  advance,
   output logic                  done,
   output tdr_pkg::telegram_type bytes
);

   localparam logic [tdr_pkg::POS_WIDTH-1:0] LAST_POS =
      tdr_pkg::POS_WIDTH'(tdr_pkg::TELEGRAM_BYTES - 1);
   localparam logic [tdr_pkg::POS_WIDTH-1:0] FULL_POS =
      tdr_pkg::POS_WIDTH'(tdr_pkg::TELEGRAM_BYTES);

   logic [tdr_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   tdr_pkg::telegram_type         bytes_ff;
   logic                          take;
   logic                          store;
   logic [tdr_pkg::POS_WIDTH-1:0] cur_pos;

   assign take    = accept & (start_flag | active_ff);
   assign cur_pos = start_flag ? '0 : pos_ff;
   assign store   = take & (cur_pos < FULL_POS);

   always_comb begin
      pos_in    = pos_ff;
      active_in = active_ff;
      done_in   = done_ff & ~advance;
      if (take) begin
         if (!store) begin
            pos_in    = '0;
            active_in = 1'b0;
         end else if (cur_pos == LAST_POS) begin
            pos_in    = '0;
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            pos_in    = cur_pos + 1'b1;
            active_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // byte buffer, no reset needed
   always_ff @(posedge clock) begin
      if (store) begin
         bytes_ff[cur_pos] <= byte_data;
      end
   end

   assign done  = done_ff;
   assign bytes = bytes_ff;

endmodule

// File: hdl/tdr_check.sv
// ----------------------------------------------------------------------------
// tdr_check
// Decodes identifier and status from a full telegram and re-encodes it with
// the recursive code to check every byte.
// ----------------------------------------------------------------------------
module tdr_check (
   input  tdr_pkg::telegram_type bytes,
   input  tdr_pkg::csr_type      regs,
   output tdr_pkg::result_type   result
);

   localparam int NSYM = tdr_pkg::SYMBOL_COUNT;

   logic [NSYM-1:0]                 src;
   logic [NSYM-1:0]                 src_rev;
   logic [NSYM:0]                   src_ext;
   logic [tdr_pkg::ID_WIDTH-1:0]    id;
   logic [tdr_pkg::STATUS_WIDTH-1:0] st;
   tdr_pkg::telegram_type           exp_bytes;
   logic                            pre_ok;
   logic                            code_ok;

   // symbol k sits in byte 2 + k/4, first symbol in the top two bits
   always_comb begin
      for (int k = 0; k < NSYM; k++) begin
         src[k] = bytes[2 + k/4][7 - 2*(k%4)] ^ bytes[2 + k/4][6 - 2*(k%4)];
      end
   end

   // stream is read from its top bit: three id bits, then one status bit
   always_comb begin
      int ii;
      int si;
      ii = 0;
      si = 0;
      id = '0;
      st = '0;
      for (int p = 0; p < NSYM; p++) begin
         if ((p % 4) != 3) begin
            id[tdr_pkg::ID_WIDTH-1-ii] = src[NSYM-1-p];
            ii = ii + 1;
         end else begin
            st[tdr_pkg::STATUS_WIDTH-1-si] = src[NSYM-1-p];
            si = si + 1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NSYM; i++) begin
         src_rev[i] = src[NSYM-1-i];
      end
   end

   assign src_ext = {1'b0, src};

   // history at step k holds src[k] in bit 0, src[k-1] in bit 1 and so on
   always_comb begin
      logic [NSYM-1:0] hist;
      logic            fb;
      logic            bit_a;
      logic            bit_b;
      exp_bytes    = '0;
      exp_bytes[0] = regs.preamble_first;
      exp_bytes[1] = regs.preamble_second;
      for (int k = 0; k < NSYM; k++) begin
         hist  = src_rev >> (NSYM - 1 - k);
         fb    = ^(hist & regs.coding_polynomial);
         bit_a = fb ^ src_ext[k+1];
         bit_b = bit_a ^ src[k];
         exp_bytes[2 + k/4][7 - 2*(k%4)] = bit_a;
         exp_bytes[2 + k/4][6 - 2*(k%4)] = bit_b;
      end
   end

   assign pre_ok  = (bytes[0] == regs.preamble_first) &
                    (bytes[1] == regs.preamble_second);
   assign code_ok = (bytes == exp_bytes);

   assign result.identifier     = id;
   assign result.status_bits    = st;
   assign result.preamble_match = pre_ok;
   assign result.code_match     = code_ok;
   assign result.id_in_range    = (id <= regs.display_id_limit);
   assign result.telegram_ok    = pre_ok & code_ok;

endmodule

// File: hdl/telegram_decoder_with_recheck.sv
// The twelfth byte is written into the byte buffer register, then the result
// register captures the decode once the result slot is free.
// Throughput: one byte per cycle; the decode and re-encode check is a single
// combinational pass from the byte buffer into the result register.
// Input stalls only while a finished telegram waits behind an unaccepted result.
// Reset: synchronous, active high; clears framing, result valid and registers.
// ----------------------------------------------------------------------------
// telegram_decoder_with_recheck
// Collects 12-byte telegrams, decodes identifier and status and re-checks the
// coding; one result beat per complete telegram.
// ----------------------------------------------------------------------------
module telegram_decoder_with_recheck (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] telegram_byte
   input  logic                                req_tuser,  // [0] start_flag
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [29:0] identifier, [39:30] status_bits, [40] preamble_match,
   // [41] code_match, [42] id_in_range, [43] telegram_ok, [47:44] zero
   output logic [tdr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [tdr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [tdr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   tdr_pkg::csr_type      regs;
   tdr_pkg::telegram_type bytes;
   tdr_pkg::result_type   result;
   tdr_pkg::result_type   rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  done;
   logic                  advance;
   logic                  req_accept;

   // check stage may move when nothing is done or the result slot frees
   assign advance    = ~done | ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid & req_tready;

   tdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .regs    (regs)
   );

   tdr_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .byte_data  (req_tdata),
      .start_flag (req_tuser),
      .advance    (advance),
      .done       (done),
      .bytes      (bytes)
   );

   tdr_check u_check (
      .bytes  (bytes),
      .regs   (regs),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tdr_pkg::RSP_DATA_WIDTH - $bits(tdr_pkg::result_type)){1'b0}},
                        rsp_data_ff};

endmodule

// File: tb/sv/telegram_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telegram_decode_checker
// Watches the register port and both streams of the telegram decoder, keeps
// its own copy of the registers and framing state, decodes and re-checks each
// complete telegram, and compares every result beat with the oldest
// prediction, field by field. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module telegram_decode_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] telegram_byte
   input  logic                                req_tuser,   // [0] start_flag
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [29:0] identifier, [39:30] status_bits, [40] preamble_match,
   // [41] code_match, [42] id_in_range, [43] telegram_ok, [47:44] zero
   input  logic [tdr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [tdr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  failures,
   output int                                  pending
);

   tdr_pkg::csr_type      cfg;
   tdr_pkg::telegram_type frame_bytes;
   logic                  frame_open;
   int                    next_index;
   tdr_pkg::result_type   expected_decodes[$];

   initial failures = 0;

   // symbol k sits in byte 2 + k/4, first symbol of a byte in the top two bits
   function automatic tdr_pkg::result_type decode_telegram(
      input tdr_pkg::telegram_type bytes);
      tdr_pkg::result_type r;
      logic [39:0]         stream;
      logic [39:0]         hist;
      logic [1:0]          pair;
      logic                nb;
      logic                a;
      logic                bad_symbol;
      int                  k;
      int                  p;
      for (k = 0; k < tdr_pkg::SYMBOL_COUNT; k++) begin
         pair      = bytes[2 + k / 4][7 - 2 * (k % 4) -: 2];
         stream[k] = pair[1] ^ pair[0];
      end
      r.identifier  = '0;
      r.status_bits = '0;
      // from the top bit down: three identifier bits, then one status bit
      for (p = 0; p < tdr_pkg::SYMBOL_COUNT; p++) begin
         if (p % 4 != 3) begin
            r.identifier = {r.identifier[tdr_pkg::ID_WIDTH-2:0], stream[39 - p]};
         end else begin
            r.status_bits = {r.status_bits[tdr_pkg::STATUS_WIDTH-2:0], stream[39 - p]};
         end
      end
      // re-encode; the packed stream is the recovered one, zero tail at the end
      bad_symbol = 1'b0;
      hist       = {39'b0, stream[0]};
      for (k = 0; k < tdr_pkg::SYMBOL_COUNT; k++) begin
         nb = (k == tdr_pkg::SYMBOL_COUNT - 1) ? 1'b0 : stream[k + 1];
         a  = (^(hist & cfg.coding_polynomial)) ^ nb;
         if (bytes[2 + k / 4][7 - 2 * (k % 4) -: 2] != {a, a ^ hist[0]})
            bad_symbol = 1'b1;
         hist = {hist[38:0], nb};
      end
      r.preamble_match = (bytes[0] == cfg.preamble_first) &&
                         (bytes[1] == cfg.preamble_second);
      r.code_match     = r.preamble_match && !bad_symbol;
      r.id_in_range    = r.identifier <= cfg.display_id_limit;
      r.telegram_ok    = r.preamble_match && r.code_match;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [39:0] want,
                                       input logic [39:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      tdr_pkg::result_type want;
      tdr_pkg::result_type got;
      if (reset) begin
         cfg.coding_polynomial = '0;
         cfg.preamble_first    = '0;
         cfg.preamble_second   = '0;
         cfg.display_id_limit  = tdr_pkg::ID_LIMIT_RESET;
         frame_open            = 1'b0;
         next_index            = 0;
         expected_decodes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (tdr_pkg::reg_index_type'(csr_paddr[tdr_pkg::CSR_ADDR_WIDTH-1:3]))
               tdr_pkg::REG_CODING_POLY:
                  cfg.coding_polynomial = csr_pwdata[tdr_pkg::POLY_WIDTH-1:0];
               tdr_pkg::REG_PREAMBLE_1:  cfg.preamble_first  = csr_pwdata[7:0];
               tdr_pkg::REG_PREAMBLE_2:  cfg.preamble_second = csr_pwdata[7:0];
               tdr_pkg::REG_ID_LIMIT:
                  cfg.display_id_limit = csr_pwdata[tdr_pkg::ID_WIDTH-1:0];
               default: ;
            endcase
         end
         // pop before push so an early beat cannot match a fresh prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(tdr_pkg::result_type)-1:0];
            if (expected_decodes.size() == 0) begin
               $display("%0t ns: result beat with no telegram outstanding, %s %0h",
                        $time, "expected none, got", rsp_tdata);
               failures++;
            end else begin
               want = expected_decodes.pop_front();
               check_field("identifier", want.identifier, got.identifier);
               check_field("status_bits", want.status_bits, got.status_bits);
               check_field("preamble_match", want.preamble_match, got.preamble_match);
               check_field("code_match", want.code_match, got.code_match);
               check_field("id_in_range", want.id_in_range, got.id_in_range);
               check_field("telegram_ok", want.telegram_ok, got.telegram_ok);
               check_field("padding", '0,
                           rsp_tdata[tdr_pkg::RSP_DATA_WIDTH-1:$bits(tdr_pkg::result_type)]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               frame_open = 1'b1;
               next_index = 0;
            end
            // bytes outside a frame are dropped
            if (frame_open) begin
               frame_bytes[next_index] = req_tdata;
               next_index++;
               if (next_index == tdr_pkg::TELEGRAM_BYTES) begin
                  frame_open = 1'b0;
                  next_index = 0;
                  expected_decodes.push_back(decode_telegram(frame_bytes));
               end
            end
         end
      end
      pending = expected_decodes.size();
   end

endmodule

// File: tb/sv/telegram_decoder_with_recheck_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telegram_decoder_with_recheck_tb
// Drives the telegram decoder with directed telegrams and then with random
// mixes of well-formed, corrupted, truncated and stray bytes under several
// register settings and idle patterns; the checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module telegram_decoder_with_recheck_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE      = 4;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata   = '0;   // [7:0] telegram_byte
   logic                               req_tuser   = 1'b0; // [0] start_flag
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   // [29:0] identifier, [39:30] status_bits, [40] preamble_match,
   // [41] code_match, [42] id_in_range, [43] telegram_ok, [47:44] zero
   logic [tdr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [tdr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [tdr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [tdr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   int failures;
   int pending;
   int cycle_count   = 0;
   int results_seen  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_ask      = 0;

   // register values as last written, used to build well-formed telegrams
   logic [tdr_pkg::POLY_WIDTH-1:0] poly_now;
   logic [7:0]                     pre_first_now;
   logic [7:0]                     pre_second_now;
   logic [tdr_pkg::ID_WIDTH-1:0]   limit_now;

   telegram_decoder_with_recheck dut (.*);

   telegram_decode_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .failures, .pending
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         results_seen <= results_seen + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random back-pressure, plus a long hold-off on request
   initial begin : receiver
      int stall;
      int hold_seen;
      stall     = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            stall     = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic tdr_pkg::telegram_type encode_telegram(
      input logic [tdr_pkg::ID_WIDTH-1:0]     id,
      input logic [tdr_pkg::STATUS_WIDTH-1:0] st);
      tdr_pkg::telegram_type t;
      logic [39:0]           s;
      logic [39:0]           hist;
      logic                  nb;
      logic                  a;
      int                    id_bit;
      int                    st_bit;
      int                    p;
      int                    k;
      id_bit = tdr_pkg::ID_WIDTH - 1;
      st_bit = tdr_pkg::STATUS_WIDTH - 1;
      for (p = 0; p < tdr_pkg::SYMBOL_COUNT; p++) begin
         if (p % 4 != 3) begin
            s[39 - p] = id[id_bit];
            id_bit--;
         end else begin
            s[39 - p] = st[st_bit];
            st_bit--;
         end
      end
      t[0] = pre_first_now;
      t[1] = pre_second_now;
      hist = {39'b0, s[0]};
      for (k = 0; k < tdr_pkg::SYMBOL_COUNT; k++) begin
         nb = (k == tdr_pkg::SYMBOL_COUNT - 1) ? 1'b0 : s[k + 1];
         a  = (^(hist & poly_now)) ^ nb;
         t[2 + k / 4][7 - 2 * (k % 4) -: 2] = {a, a ^ hist[0]};
         hist = {hist[38:0], nb};
      end
      return t;
   endfunction

   function automatic logic [tdr_pkg::ID_WIDTH-1:0] pick_identifier();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return limit_now;
         3: return (limit_now == '1) ? limit_now : limit_now + 1'b1;
         default: return tdr_pkg::ID_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [tdr_pkg::STATUS_WIDTH-1:0] pick_status();
      return ($urandom_range(7) == 0) ? '0 : tdr_pkg::STATUS_WIDTH'($urandom);
   endfunction

   // leaves tvalid high after the beat so back-to-back beats need no toggle
   task automatic send_byte(input logic [7:0] value, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_telegram(input tdr_pkg::telegram_type t, input int count);
      int k;
      for (k = 0; k < count; k++)
         send_byte(t[k], k == 0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input tdr_pkg::reg_index_type idx,
                            input logic [tdr_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_config(input logic [tdr_pkg::POLY_WIDTH-1:0] poly,
                               input logic [7:0] first, input logic [7:0] second,
                               input logic [tdr_pkg::ID_WIDTH-1:0] limit);
      csr_write(tdr_pkg::REG_CODING_POLY, tdr_pkg::CSR_DATA_WIDTH'(poly));
      csr_write(tdr_pkg::REG_PREAMBLE_1, tdr_pkg::CSR_DATA_WIDTH'(first));
      csr_write(tdr_pkg::REG_PREAMBLE_2, tdr_pkg::CSR_DATA_WIDTH'(second));
      csr_write(tdr_pkg::REG_ID_LIMIT, tdr_pkg::CSR_DATA_WIDTH'(limit));
      poly_now       = poly;
      pre_first_now  = first;
      pre_second_now = second;
      limit_now      = limit;
   endtask

   task automatic run_random(input int item_goal, input int result_goal);
      tdr_pkg::telegram_type t;
      int                    items;
      int                    first_result;
      int                    kind;
      int                    n;
      int                    k;
      int                    flip_byte;
      int                    flip_bit;
      items        = 0;
      first_result = results_seen;
      while (items < item_goal || results_seen - first_result < result_goal) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            t = encode_telegram(pick_identifier(), pick_status());
            // some well-formed telegrams get one bit flipped
            if (kind >= 55) begin
               flip_byte = $urandom_range(tdr_pkg::TELEGRAM_BYTES - 1);
               flip_bit  = $urandom_range(7);
               t[flip_byte][flip_bit] = ~t[flip_byte][flip_bit];
            end
            send_telegram(t, tdr_pkg::TELEGRAM_BYTES);
            items += tdr_pkg::TELEGRAM_BYTES;
         end else if (kind < 80) begin
            for (k = 0; k < tdr_pkg::TELEGRAM_BYTES; k++)
               t[k] = 8'($urandom);
            send_telegram(t, tdr_pkg::TELEGRAM_BYTES);
            items += tdr_pkg::TELEGRAM_BYTES;
         end else if (kind < 90) begin
            // truncated telegram, cut short by the next start or continued by noise
            n = $urandom_range(1, tdr_pkg::TELEGRAM_BYTES - 1);
            send_telegram(encode_telegram(pick_identifier(), pick_status()), n);
            items += n;
         end else begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
               send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      int k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      write_config(40'h8_d3a5_1c27, 8'h7e, 8'h81, 30'h1000_0000);
      send_byte(8'hff, 1'b0);                  // no frame open: dropped
      send_byte(8'h00, 1'b1);                  // partial frame, abandoned below
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_telegram(encode_telegram('1, '1), tdr_pkg::TELEGRAM_BYTES);
      send_byte(8'h00, 1'b0);                  // frame already closed: dropped
      drain();

      send_idle_pct = 10;
      recv_idle_pct = 74;
      write_config('0, 8'h00, 8'hff, '0);
      run_random(110, 8);
      drain();

      send_idle_pct = 74;
      recv_idle_pct = 10;
      write_config('1, 8'hff, 8'h00, '1);
      run_random(110, 8);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_config(tdr_pkg::POLY_WIDTH'({$urandom, $urandom}), 8'($urandom), 8'($urandom),
                   tdr_pkg::ID_WIDTH'($urandom));
      run_random(50, 4);
      // receiver holds off while telegrams keep coming, so the input stalls
      hold_ask++;
      for (k = 0; k < 4; k++)
         send_telegram(encode_telegram(pick_identifier(), pick_status()),
                       tdr_pkg::TELEGRAM_BYTES);
      // sender pauses until everything is back
      drain();
      run_random(50, 4);
      drain();

      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
